### sv/mei_pkg.sv
// Shared types and constants for the escape-time iteration block.
`timescale 1ns / 1ps

package mei_pkg;

    // Field widths of the stream beats and configuration registers
    localparam int Z_W     = 64;
    localparam int CNT_W   = 31;
    localparam int SIZE_W  = 13;
    localparam int LIMIT_W = 16;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;

    // Result beat: z_real_out, z_imag_out, iter_count_out, padded to bytes
    localparam int OUT_W       = 2 * Z_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Escape thresholds in whole units
    localparam int ESCAPE_ABS = 1000;
    localparam int ESCAPE_SQ  = 1000000;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_STEP_LIMIT   = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_CHECK,
        ST_SQ_X,
        ST_SQ_Y,
        ST_TEST,
        ST_CROSS,
        ST_FINISH
    } mei_state_t;

endpackage

### sv/mei_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mei_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    import mei_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DEN_W-1:0]    den_reg;

    logic [DEN_W:0]      trial;
    logic                q_bit;
    logic [DEN_W-1:0]    rem_next;
    logic [NUM_W-1:0]    quo_next;

    // Shift in the next dividend bit and subtract the divisor when it fits
    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        q_bit = (trial >= {1'b0, den_reg});
        if (q_bit) begin
            rem_next = DEN_W'(trial - {1'b0, den_reg});
        end else begin
            rem_next = trial[DEN_W-1:0];
        end
        quo_next = {quo_reg[NUM_W-2:0], q_bit};
    end

    // Step counter and busy/done control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend, remainder and divisor registers
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### sv/mei_fx_mul.sv
// Signed 64x64 fixed-point multiplier built from four 33x33 partial products.
`timescale 1ns / 1ps

module mei_fx_mul #(
    parameter int FRAC_BITS = 36
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [mei_pkg::Z_W-1:0] op_a,
    input  logic signed [mei_pkg::Z_W-1:0] op_b,
    output logic                        done,
    output logic [mei_pkg::Z_W-1:0]     product
);
    import mei_pkg::*;

    localparam int HALF_W = Z_W / 2;
    localparam int PART_W = 2 * (HALF_W + 1);
    localparam int ACC_W  = 2 * Z_W;

    logic                    issue_reg;
    logic                    pv_reg;
    logic                    pl_reg;
    logic                    done_reg;
    logic [1:0]              idx_reg;
    logic [1:0]              wt_reg;
    logic signed [PART_W-1:0] part_reg;
    logic [ACC_W-1:0]        acc_reg;

    logic signed [HALF_W:0]  a_part;
    logic signed [HALF_W:0]  b_part;
    logic signed [PART_W-1:0] part_next;
    logic [ACC_W-1:0]        part_ext;
    logic [ACC_W-1:0]        term;

    // Pick the operand halves: upper halves signed, lower halves unsigned
    always_comb begin
        if (idx_reg[1]) begin
            a_part = {op_a[Z_W-1], op_a[Z_W-1:HALF_W]};
        end else begin
            a_part = {1'b0, op_a[HALF_W-1:0]};
        end
        if (idx_reg[0]) begin
            b_part = {op_b[Z_W-1], op_b[Z_W-1:HALF_W]};
        end else begin
            b_part = {1'b0, op_b[HALF_W-1:0]};
        end
        part_next = a_part * b_part;
    end

    // Weight the registered partial product by its half position
    always_comb begin
        part_ext = ACC_W'(part_reg);
        case (wt_reg)
            2'd0:    term = part_ext;
            2'd1:    term = part_ext << HALF_W;
            2'd2:    term = part_ext << Z_W;
            default: term = '0;
        endcase
    end

    // Issue four partial products; each is registered and added to the accumulator in the cycle after its issue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            pv_reg    <= 1'b0;
            pl_reg    <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                issue_reg <= 1'b1;
                idx_reg   <= '0;
                pv_reg    <= 1'b0;
            end else if (issue_reg) begin
                pv_reg  <= 1'b1;
                pl_reg  <= (idx_reg == 2'd3);
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == 2'd3) begin
                    issue_reg <= 1'b0;
                end
            end else begin
                pv_reg <= 1'b0;
            end
            if (pv_reg && pl_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    // Partial product and accumulator payload
    always_ff @(posedge aclk) begin
        if (issue_reg) begin
            part_reg <= part_next;
            wt_reg   <= {1'b0, idx_reg[1]} + {1'b0, idx_reg[0]};
        end
        if (start) begin
            acc_reg <= '0;
        end else if (pv_reg) begin
            acc_reg <= acc_reg + term;
        end
    end

    // Arithmetic shift right by the fraction width rounds toward minus infinity
    assign done    = done_reg;
    assign product = acc_reg[FRAC_BITS+Z_W-1:FRAC_BITS];

endmodule

### sv/mandelbrot_escape_iterate_top.sv
// Top level of the resumable escape-time iteration block.
`timescale 1ns / 1ps

// Takes one pixel beat (column, row, z and iteration count), maps the pixel to
// c = (4*col/width - 2, 4*row/height - 2) in signed fixed point with FRAC_BITS
// fraction bits, then repeats z = z*z + c up to step_limit times, stopping
// early once |z|^2 reaches 1000000 or either part of z reaches 1000 in size,
// and returns one beat with the new z and the saturating count. One item is in
// work at a time and s_tready is low meanwhile. The two coordinate divisions
// run one after the other through one bit-serial divider. Each iteration runs
// three 64x64 products through one shared 33x33 multiplier. A finished result
// waits in the output register while the next beat is accepted.
module mandelbrot_escape_iterate_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 36
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [mei_pkg::CFG_A_W-1:0]       cfg_addr,
    input  logic [mei_pkg::CFG_D_W-1:0]       cfg_wdata,
    // Input beat: pixel_col, pixel_row, z_real_in, z_imag_in, iter_count_in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((2*COORD_BITS+2*mei_pkg::Z_W+mei_pkg::CNT_W+7)/8)*8-1:0] s_tdata,
    // Result beat: z_real_out, z_imag_out, iter_count_out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mei_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import mei_pkg::*;

    localparam int NUM_W   = COORD_BITS + 2 + FRAC_BITS;
    localparam int ZR_LO   = 2 * COORD_BITS;
    localparam int ZI_LO   = ZR_LO + Z_W;
    localparam int CNT_LO  = ZI_LO + Z_W;
    localparam int OUT_PAD = OUT_TDATA_W - OUT_W;

    localparam logic signed [Z_W-1:0] ABS_LIM = Z_W'(ESCAPE_ABS) << FRAC_BITS;
    localparam logic signed [Z_W-1:0] NEG_LIM = -ABS_LIM;
    localparam logic [Z_W-1:0]        SQ_LIM  = Z_W'(ESCAPE_SQ) << FRAC_BITS;
    localparam logic [Z_W-1:0]        C_BIAS  = Z_W'(2) << FRAC_BITS;

    // Configuration registers
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Sequencer and working registers
    mei_state_t               state_reg, state_next;
    logic [COORD_BITS-1:0]    row_reg;
    logic signed [Z_W-1:0]    x_reg;
    logic signed [Z_W-1:0]    y_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [LIMIT_W-1:0]       n_reg;
    logic [Z_W-1:0]           cx_reg;
    logic [Z_W-1:0]           cy_reg;
    logic [Z_W-1:0]           xx_reg;
    logic [Z_W-1:0]           yy_reg;
    logic [Z_W-1:0]           diff_reg;

    // Output register
    logic                     out_valid_reg;
    logic [Z_W-1:0]           out_x_reg;
    logic [Z_W-1:0]           out_y_reg;
    logic [CNT_W-1:0]         out_cnt_reg;

    // Control strobes from the sequencer
    logic take_in, ld_cx, ld_cy, ld_xx, ld_yy, ld_diff, ld_step, out_load;
    logic div_start, mul_start;

    // Shared units
    logic [NUM_W-1:0]   div_num;
    logic [SIZE_W-1:0]  div_den;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    logic signed [Z_W-1:0] mul_a;
    logic signed [Z_W-1:0] mul_b;
    logic               mul_done;
    logic [Z_W-1:0]     mul_prod;

    logic [COORD_BITS-1:0] in_col;
    logic [Z_W-1:0]        c_val;
    logic                  big_xy;
    logic                  sq_escape;
    logic [CNT_W-1:0]      cnt_inc;

    assign in_col = s_tdata[COORD_BITS-1:0];

    // Divider operands: column at accept, row after the first quotient
    always_comb begin
        if (state_reg == ST_IDLE) begin
            div_num = NUM_W'(in_col) << (FRAC_BITS + 2);
            div_den = (width_reg == '0) ? SIZE_W'(1) : width_reg;
        end else begin
            div_num = NUM_W'(row_reg) << (FRAC_BITS + 2);
            div_den = (height_reg == '0) ? SIZE_W'(1) : height_reg;
        end
    end

    // Multiplier operands follow the state that owns the product
    always_comb begin
        case (state_reg)
            ST_SQ_Y: begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            ST_CROSS: begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            default: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    mei_div #(
        .NUM_W (NUM_W),
        .DEN_W (SIZE_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    mei_fx_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Escape tests and helpers
    assign c_val     = Z_W'(div_quot) - C_BIAS;
    assign big_xy    = (x_reg >= ABS_LIM) || (x_reg <= NEG_LIM) ||
                       (y_reg >= ABS_LIM) || (y_reg <= NEG_LIM);
    assign sq_escape = ((xx_reg + yy_reg) >= SQ_LIM);
    assign cnt_inc   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // Next state and strobes
    always_comb begin
        state_next = state_reg;
        take_in    = 1'b0;
        ld_cx      = 1'b0;
        ld_cy      = 1'b0;
        ld_xx      = 1'b0;
        ld_yy      = 1'b0;
        ld_diff    = 1'b0;
        ld_step    = 1'b0;
        out_load   = 1'b0;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    take_in    = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (div_done) begin
                    ld_cx      = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_done) begin
                    ld_cy      = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if ((n_reg == limit_reg) || big_xy) begin
                    state_next = ST_FINISH;
                end else begin
                    mul_start  = 1'b1;
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                if (mul_done) begin
                    ld_xx      = 1'b1;
                    mul_start  = 1'b1;
                    state_next = ST_SQ_Y;
                end
            end
            ST_SQ_Y: begin
                if (mul_done) begin
                    ld_yy      = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (sq_escape) begin
                    state_next = ST_FINISH;
                end else begin
                    ld_diff    = 1'b1;
                    mul_start  = 1'b1;
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS: begin
                if (mul_done) begin
                    ld_step    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            width_reg  <= SIZE_W'(1024);
            height_reg <= SIZE_W'(1024);
            limit_reg  <= LIMIT_W'(64);
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[SIZE_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[SIZE_W-1:0];
                    REG_STEP_LIMIT:   limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working registers: capture the beat, then advance one step at a time
    always_ff @(posedge aclk) begin
        if (take_in) begin
            row_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            x_reg   <= s_tdata[ZR_LO+Z_W-1:ZR_LO];
            y_reg   <= s_tdata[ZI_LO+Z_W-1:ZI_LO];
            cnt_reg <= s_tdata[CNT_LO+CNT_W-1:CNT_LO];
            n_reg   <= '0;
        end
        if (ld_cx) begin
            cx_reg <= c_val;
        end
        if (ld_cy) begin
            cy_reg <= c_val;
        end
        if (ld_xx) begin
            xx_reg <= mul_prod;
        end
        if (ld_yy) begin
            yy_reg <= mul_prod;
        end
        if (ld_diff) begin
            diff_reg <= xx_reg - yy_reg;
        end
        if (ld_step) begin
            x_reg   <= diff_reg + cx_reg;
            y_reg   <= {mul_prod[Z_W-2:0], 1'b0} + cy_reg;
            cnt_reg <= cnt_inc;
            n_reg   <= n_reg + 1'b1;
        end
    end

    // Output register: hold the result until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg   <= x_reg;
            out_y_reg   <= y_reg;
            out_cnt_reg <= cnt_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_cnt_reg, out_y_reg, out_x_reg};

endmodule
